@@ sv/sbsh_pkg.sv @@
package sbsh_pkg;

  localparam int unsigned BLOCK_WORDS = 16;
  localparam int unsigned ROUNDS = 64;

  localparam logic [5:0] LAST_BYTE_POS = 6'd63;
  localparam logic [5:0] LEN_POS = 6'd56;
  localparam logic [7:0] PAD_BYTE = 8'h80;
  localparam logic [63:0] BYTE_BITS = 64'd8;

  typedef enum logic [1:0] {
    KIND_APPEND      = 2'd0,
    KIND_APPEND_LAST = 2'd1,
    KIND_FINISH      = 2'd2
  } sbsh_kind_e;

  typedef enum logic [2:0] {
    ST_IDLE,
    ST_MARK,
    ST_ZERO,
    ST_LEN,
    ST_COMP,
    ST_OUT
  } sbsh_state_e;

  typedef struct packed {
    logic        wr_byte;
    logic [5:0]  wr_pos;
    logic [7:0]  wr_data;
    logic        wr_len;
    logic [63:0] len;
    logic        start;
    logic        chain_init;
  } sbsh_cmd_t;

  typedef struct packed {
    logic busy;
    logic done;
  } sbsh_status_t;

  localparam logic [31:0] INIT_H [8] = '{
    32'h6a09e667, 32'hbb67ae85, 32'h3c6ef372, 32'ha54ff53a,
    32'h510e527f, 32'h9b05688c, 32'h1f83d9ab, 32'h5be0cd19
  };

  localparam logic [31:0] ROUND_K [64] = '{
    32'h428a2f98, 32'h71374491, 32'hb5c0fbcf, 32'he9b5dba5,
    32'h3956c25b, 32'h59f111f1, 32'h923f82a4, 32'hab1c5ed5,
    32'hd807aa98, 32'h12835b01, 32'h243185be, 32'h550c7dc3,
    32'h72be5d74, 32'h80deb1fe, 32'h9bdc06a7, 32'hc19bf174,
    32'he49b69c1, 32'hefbe4786, 32'h0fc19dc6, 32'h240ca1cc,
    32'h2de92c6f, 32'h4a7484aa, 32'h5cb0a9dc, 32'h76f988da,
    32'h983e5152, 32'ha831c66d, 32'hb00327c8, 32'hbf597fc7,
    32'hc6e00bf3, 32'hd5a79147, 32'h06ca6351, 32'h14292967,
    32'h27b70a85, 32'h2e1b2138, 32'h4d2c6dfc, 32'h53380d13,
    32'h650a7354, 32'h766a0abb, 32'h81c2c92e, 32'h92722c85,
    32'ha2bfe8a1, 32'ha81a664b, 32'hc24b8b70, 32'hc76c51a3,
    32'hd192e819, 32'hd6990624, 32'hf40e3585, 32'h106aa070,
    32'h19a4c116, 32'h1e376c08, 32'h2748774c, 32'h34b0bcb5,
    32'h391c0cb3, 32'h4ed8aa4a, 32'h5b9cca4f, 32'h682e6ff3,
    32'h748f82ee, 32'h78a5636f, 32'h84c87814, 32'h8cc70208,
    32'h90befffa, 32'ha4506ceb, 32'hbef9a3f7, 32'hc67178f2
  };

endpackage

@@ sv/sbsh_compress.sv @@
module sbsh_compress
  import sbsh_pkg::*;
(
  input  logic               clk_i,
  input  logic               rst_ni,
  input  sbsh_cmd_t          cmd_i,
  output sbsh_status_t       status_o,
  output logic [7:0][31:0]   digest_o
);

  logic [31:0]      w_q [BLOCK_WORDS];
  logic [7:0][31:0] var_q;
  logic [7:0][31:0] chain_q;
  logic [5:0]       rnd_q;
  logic             busy_q;
  logic             fin_q;

  logic [31:0] w_new;
  logic [31:0] t1;
  logic [31:0] t2;
  logic [31:0] big_s0;
  logic [31:0] big_s1;
  logic [31:0] ch;
  logic [31:0] maj;
  logic [31:0] sm0;
  logic [31:0] sm1;
  logic        rounding;

  function automatic logic [31:0] rotr(input logic [31:0] x, input int unsigned n);
    return (x >> n) | (x << (32 - n));
  endfunction

  assign rounding = busy_q && !fin_q;

  always_comb begin
    sm0    = rotr(w_q[1], 7) ^ rotr(w_q[1], 18) ^ (w_q[1] >> 3);
    sm1    = rotr(w_q[14], 17) ^ rotr(w_q[14], 19) ^ (w_q[14] >> 10);
    w_new  = w_q[0] + sm0 + w_q[9] + sm1;
    big_s1 = rotr(var_q[4], 6) ^ rotr(var_q[4], 11) ^ rotr(var_q[4], 25);
    ch     = (var_q[4] & var_q[5]) ^ (~var_q[4] & var_q[6]);
    t1     = var_q[7] + big_s1 + ch + ROUND_K[rnd_q] + w_q[0];
    big_s0 = rotr(var_q[0], 2) ^ rotr(var_q[0], 13) ^ rotr(var_q[0], 22);
    maj    = (var_q[0] & var_q[1]) ^ (var_q[0] & var_q[2]) ^ (var_q[1] & var_q[2]);
    t2     = big_s0 + maj;
  end

  always_ff @(posedge clk_i) begin
    if (rounding) begin
      for (int i = 0; i < BLOCK_WORDS - 1; i++) begin
        w_q[i] <= w_q[i+1];
      end
      w_q[BLOCK_WORDS-1] <= w_new;
    end else begin
      if (cmd_i.wr_byte) begin
        w_q[cmd_i.wr_pos[5:2]][{~cmd_i.wr_pos[1:0], 3'b000} +: 8] <= cmd_i.wr_data;
      end
      if (cmd_i.wr_len) begin
        w_q[BLOCK_WORDS-2] <= cmd_i.len[63:32];
        w_q[BLOCK_WORDS-1] <= cmd_i.len[31:0];
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (cmd_i.start && !busy_q) begin
      var_q <= chain_q;
    end else if (rounding) begin
      var_q[7] <= var_q[6];
      var_q[6] <= var_q[5];
      var_q[5] <= var_q[4];
      var_q[4] <= var_q[3] + t1;
      var_q[3] <= var_q[2];
      var_q[2] <= var_q[1];
      var_q[1] <= var_q[0];
      var_q[0] <= t1 + t2;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      busy_q <= 1'b0;
      fin_q  <= 1'b0;
      rnd_q  <= '0;
      for (int i = 0; i < 8; i++) begin
        chain_q[i] <= INIT_H[i];
      end
    end else begin
      if (fin_q) begin
        busy_q <= 1'b0;
        fin_q  <= 1'b0;
        for (int i = 0; i < 8; i++) begin
          chain_q[i] <= chain_q[i] + var_q[i];
        end
      end else if (rounding) begin
        rnd_q <= rnd_q + 6'd1;
        if (rnd_q == 6'(ROUNDS - 1)) begin
          fin_q <= 1'b1;
        end
      end else if (cmd_i.start) begin
        busy_q <= 1'b1;
        rnd_q  <= '0;
      end else if (cmd_i.chain_init) begin
        for (int i = 0; i < 8; i++) begin
          chain_q[i] <= INIT_H[i];
        end
      end
    end
  end

  assign status_o.busy = busy_q;
  assign status_o.done = fin_q;
  assign digest_o      = chain_q;

  a_fin_in_busy: assert property (@(posedge clk_i) disable iff (!rst_ni)
    fin_q |-> busy_q)
    else $error("feed-forward cycle outside a compression");

  a_start_idle: assert property (@(posedge clk_i) disable iff (!rst_ni)
    cmd_i.start |-> !busy_q)
    else $error("compression started while busy");

  a_last_round: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (rounding && rnd_q == 6'(ROUNDS - 1)) |=> fin_q)
    else $error("last round not followed by feed-forward");

endmodule

@@ sv/sha256_byte_stream_hasher_unit.sv @@
// Message bytes are taken one item per cycle while the block buffer fills.
// The item that completes a 64-byte block stalls input while
// one shared round unit runs 64 rounds, one per cycle, then adds the chain.
// A finishing item pads one byte per cycle outside compressions, over up to two blocks,
// runs one or two compressions and loads the digest into the output register once that register is free.
// Reset is asynchronous and active low; it restores the initial hash values.
module sha256_byte_stream_hasher_unit
  import sbsh_pkg::*;
(
  input  logic         clk_i,
  input  logic         rst_ni,
  input  logic         s_axis_tvalid_i,
  output logic         s_axis_tready_o,
  input  logic [7:0]   s_axis_tdata_i,  // [7:0] data_byte
  input  logic [1:0]   s_axis_tuser_i,  // [1:0] kind
  output logic         m_axis_tvalid_o,
  input  logic         m_axis_tready_i,
  output logic [255:0] m_axis_tdata_o   // digest_word_0 in [31:0] up to digest_word_7
);

  sbsh_state_e      state_q, state_d;
  sbsh_state_e      ret_q, ret_d;
  logic [5:0]       fc_q, fc_d;
  logic [63:0]      bits_q, bits_d;
  logic             out_valid_q, out_valid_d;
  logic [255:0]     out_q;
  logic             out_load;
  sbsh_cmd_t        cmd;
  sbsh_status_t     st;
  logic [7:0][31:0] digest;

  sbsh_compress u_compress (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .cmd_i   (cmd),
    .status_o(st),
    .digest_o(digest)
  );

  always_comb begin
    state_d     = state_q;
    ret_d       = ret_q;
    fc_d        = fc_q;
    bits_d      = bits_q;
    out_valid_d = out_valid_q;
    out_load    = 1'b0;
    cmd         = '0;
    cmd.len     = bits_q;
    unique case (state_q)
      ST_IDLE: begin
        if (s_axis_tvalid_i) begin
          unique case (sbsh_kind_e'(s_axis_tuser_i))
            KIND_APPEND, KIND_APPEND_LAST: begin
              cmd.wr_byte = 1'b1;
              cmd.wr_pos  = fc_q;
              cmd.wr_data = s_axis_tdata_i;
              fc_d        = fc_q + 6'd1;
              bits_d      = bits_q + BYTE_BITS;
              ret_d       = (sbsh_kind_e'(s_axis_tuser_i) == KIND_APPEND) ? ST_IDLE : ST_MARK;
              if (fc_q == LAST_BYTE_POS) begin
                cmd.start = 1'b1;
                state_d   = ST_COMP;
              end else begin
                state_d = ret_d;
              end
            end
            KIND_FINISH: state_d = ST_MARK;
            default: ;
          endcase
        end
      end
      ST_MARK: begin
        cmd.wr_byte = 1'b1;
        cmd.wr_pos  = fc_q;
        cmd.wr_data = PAD_BYTE;
        fc_d        = fc_q + 6'd1;
        ret_d       = ST_ZERO;
        if (fc_q == LAST_BYTE_POS) begin
          cmd.start = 1'b1;
          state_d   = ST_COMP;
        end else begin
          state_d = ST_ZERO;
        end
      end
      ST_ZERO: begin
        if (fc_q == LEN_POS) begin
          state_d = ST_LEN;
        end else begin
          cmd.wr_byte = 1'b1;
          cmd.wr_pos  = fc_q;
          fc_d        = fc_q + 6'd1;
          ret_d       = ST_ZERO;
          if (fc_q == LAST_BYTE_POS) begin
            cmd.start = 1'b1;
            state_d   = ST_COMP;
          end
        end
      end
      ST_LEN: begin
        cmd.wr_len = 1'b1;
        cmd.start  = 1'b1;
        ret_d      = ST_OUT;
        state_d    = ST_COMP;
      end
      ST_COMP: begin
        if (st.done) begin
          state_d = ret_q;
        end
      end
      ST_OUT: begin
        if (!out_valid_q || m_axis_tready_i) begin
          out_load       = 1'b1;
          out_valid_d    = 1'b1;
          cmd.chain_init = 1'b1;
          fc_d           = '0;
          bits_d         = '0;
          state_d        = ST_IDLE;
        end
      end
      default: state_d = ST_IDLE;
    endcase
    if (out_valid_q && m_axis_tready_i && !out_load) begin
      out_valid_d = 1'b0;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= ST_IDLE;
      ret_q       <= ST_IDLE;
      fc_q        <= '0;
      bits_q      <= '0;
      out_valid_q <= 1'b0;
    end else begin
      state_q     <= state_d;
      ret_q       <= ret_d;
      fc_q        <= fc_d;
      bits_q      <= bits_d;
      out_valid_q <= out_valid_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (out_load) begin
      out_q <= digest;
    end
  end

  assign s_axis_tready_o = (state_q == ST_IDLE);
  assign m_axis_tvalid_o = out_valid_q;
  assign m_axis_tdata_o  = out_q;

  a_ready_not_busy: assert property (@(posedge clk_i) disable iff (!rst_ni)
    s_axis_tready_o |-> !st.busy)
    else $error("input ready while the round unit is busy");

  a_len_starts: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (state_q == ST_LEN) |=> (state_q == ST_COMP && st.busy))
    else $error("length write did not start the final compression");

  a_out_loaded: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_load |=> (out_valid_q && state_q == ST_IDLE))
    else $error("digest not presented after loading");

endmodule
